// ===== src/mm3_pkg.sv =====
// ----------------------------------------------------------------------------
// mm3_pkg
// Constants and sequencer state type for the MurmurHash3 key hasher.
// ----------------------------------------------------------------------------
package mm3_pkg;

    // Block scramble and mix constants.
    localparam logic [31:0] C1_CONST = 32'hcc9e2d51;
    localparam logic [31:0] C2_CONST = 32'h1b873593;
    localparam logic [31:0] N_CONST  = 32'he6546b64;

    // Finalization multipliers.
    localparam logic [31:0] F1_CONST = 32'h85ebca6b;
    localparam logic [31:0] F2_CONST = 32'hc2b2ae35;

    // Sequencer states, one-hot.
    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,  // waiting for an item
        ST_W_C2  = 8'b0000_0010,  // word * C1 ready, issue rotate * C2
        ST_W_MIX = 8'b0000_0100,  // scrambled word ready, mix into hash
        ST_FIN   = 8'b0000_1000,  // start tail or finalization
        ST_T_C2  = 8'b0001_0000,  // tail * C1 ready, issue rotate * C2
        ST_T_XOR = 8'b0010_0000,  // scrambled tail ready, xor into hash
        ST_F_M2  = 8'b0100_0000,  // first fmix product ready
        ST_F_OUT = 8'b1000_0000   // second fmix product ready, emit
    } state_t;

    function automatic logic [31:0] rotl15(input logic [31:0] v);
        rotl15 = {v[16:0], v[31:17]};
    endfunction

    function automatic logic [31:0] rotl13(input logic [31:0] v);
        rotl13 = {v[18:0], v[31:19]};
    endfunction

endpackage

// ===== src/murmur3_32_key_hash.sv =====
// ----------------------------------------------------------------------------
// murmur3_32_key_hash: seeded MurmurHash3 x86_32 over a key, one byte per item.
// A new item is taken only in the idle state; a byte that completes a word,
// and the last item of a key, first pass through the shared multiplier.
// The hash goes through the tail and finalization states to the output
// register, waiting in the last state while an earlier hash is untaken.
// Synchronous active-low reset clears hash, pending bytes, phase and length.
// ----------------------------------------------------------------------------
module murmur3_32_key_hash (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [31:0] key_seed, [39:32] key_byte
    input  logic [1:0]  s_tuser,   // [0] byte_present, [1] first_of_key
    input  logic        s_tlast,   // last_of_key
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [31:0] hash_value
);
    import mm3_pkg::*;

    state_t      state_reg, state_next;
    logic [31:0] hash_reg, hash_next;
    logic [23:0] pend_reg, pend_next;
    logic [1:0]  phase_reg, phase_next;
    logic [31:0] len_reg, len_next;
    logic        last_reg, last_next;
    logic        out_valid_reg, out_valid_next;
    logic [31:0] out_data_reg, out_data_next;

    logic        mul_issue;
    logic [31:0] mul_a, mul_b, prod;

    logic        accept;
    logic [31:0] key_seed;
    logic [7:0]  key_byte;
    logic        byte_present, first_of_key;
    logic [31:0] base_hash, base_len;
    logic [23:0] base_pend;
    logic [1:0]  base_phase;
    logic [31:0] mixed, fin_h, fmix_out;
    logic        out_free;

    // Unpack the input item.
    assign key_seed     = s_tdata[31:0];
    assign key_byte     = s_tdata[39:32];
    assign byte_present = s_tuser[0];
    assign first_of_key = s_tuser[1];

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    // State after an optional restart by the first mark.
    assign base_hash  = first_of_key ? key_seed : hash_reg;
    assign base_len   = first_of_key ? 32'd0 : len_reg;
    assign base_pend  = first_of_key ? 24'd0 : pend_reg;
    assign base_phase = first_of_key ? 2'd0 : phase_reg;

    // Word mix: rotate the xored hash, then times 5 plus N by shift and add.
    assign mixed = (rotl13(hash_reg ^ prod) << 2) + rotl13(hash_reg ^ prod) + N_CONST;

    // Finalization input and last fmix step.
    assign fin_h    = (hash_reg ^ len_reg) ^ ((hash_reg ^ len_reg) >> 16);
    assign fmix_out = prod ^ (prod >> 16);

    mm3_mul u_mul (
        .aclk  (aclk),
        .issue (mul_issue),
        .op_a  (mul_a),
        .op_b  (mul_b),
        .prod  (prod)
    );

    // Sequencer and datapath next-state logic.
    always_comb begin
        state_next     = state_reg;
        hash_next      = hash_reg;
        pend_next      = pend_reg;
        phase_next     = phase_reg;
        len_next       = len_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        mul_issue      = 1'b0;
        mul_a          = prod;
        mul_b          = C2_CONST;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    hash_next  = base_hash;
                    pend_next  = base_pend;
                    phase_next = base_phase;
                    len_next   = base_len + {31'd0, byte_present};
                    last_next  = s_tlast;
                    if (byte_present && base_phase == 2'd3) begin
                        // Fourth byte completes a little-endian word.
                        mul_issue  = 1'b1;
                        mul_a      = {key_byte, base_pend};
                        mul_b      = C1_CONST;
                        pend_next  = 24'd0;
                        phase_next = 2'd0;
                        state_next = ST_W_C2;
                    end else begin
                        if (byte_present) begin
                            case (base_phase)
                                2'd0:    pend_next = {base_pend[23:8], key_byte};
                                2'd1:    pend_next = {base_pend[23:16], key_byte,
                                                      base_pend[7:0]};
                                default: pend_next = {key_byte, base_pend[15:0]};
                            endcase
                            phase_next = base_phase + 2'd1;
                        end
                        if (s_tlast) begin
                            state_next = ST_FIN;
                        end
                    end
                end
            end
            ST_W_C2: begin
                mul_issue  = 1'b1;
                mul_a      = rotl15(prod);
                mul_b      = C2_CONST;
                state_next = ST_W_MIX;
            end
            ST_W_MIX: begin
                hash_next  = mixed;
                state_next = last_reg ? ST_FIN : ST_IDLE;
            end
            ST_FIN: begin
                mul_issue = 1'b1;
                if (phase_reg != 2'd0) begin
                    // Scramble the one to three tail bytes first.
                    mul_a      = {8'd0, pend_reg};
                    mul_b      = C1_CONST;
                    state_next = ST_T_C2;
                end else begin
                    mul_a      = fin_h;
                    mul_b      = F1_CONST;
                    state_next = ST_F_M2;
                end
            end
            ST_T_C2: begin
                mul_issue  = 1'b1;
                mul_a      = rotl15(prod);
                mul_b      = C2_CONST;
                state_next = ST_T_XOR;
            end
            ST_T_XOR: begin
                hash_next  = hash_reg ^ prod;
                phase_next = 2'd0;
                state_next = ST_FIN;
            end
            ST_F_M2: begin
                mul_issue  = 1'b1;
                mul_a      = prod ^ (prod >> 13);
                mul_b      = F2_CONST;
                state_next = ST_F_OUT;
            end
            ST_F_OUT: begin
                // Hold the finished hash until the output register is free.
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_data_next  = fmix_out;
                    hash_next      = 32'd0;
                    pend_next      = 24'd0;
                    phase_next     = 2'd0;
                    len_next       = 32'd0;
                    last_next      = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            hash_reg      <= 32'd0;
            pend_reg      <= 24'd0;
            phase_reg     <= 2'd0;
            len_reg       <= 32'd0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            hash_reg      <= hash_next;
            pend_reg      <= pend_next;
            phase_reg     <= phase_next;
            len_reg       <= len_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload register.
    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ===== src/mm3_mul.sv =====
// ----------------------------------------------------------------------------
// mm3_mul
// Shared 32x32 multiplier keeping the low 32 bits, with a registered product.
// ----------------------------------------------------------------------------
module mm3_mul (
    input  logic        aclk,
    input  logic        issue,
    input  logic [31:0] op_a,
    input  logic [31:0] op_b,
    output logic [31:0] prod
);
    logic [31:0] full_prod;
    logic [31:0] prod_reg;

    // One multiply per issue; the product is held until the next issue.
    assign full_prod = op_a * op_b;

    always_ff @(posedge aclk) begin
        if (issue) begin
            prod_reg <= full_prod;
        end
    end

    assign prod = prod_reg;

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the streaming MurmurHash3 x86_32 key hasher.
// Keys are streamed one byte per item with random seeds, lengths and
// content. They include empty keys, keys without a first mark, keys closed
// by a no-byte last item, abandoned keys and stray no-byte items. A
// scoreboard computes each expected hash as items are accepted and compares
// it with the hashes that come out. Both sides idle in random bursts.
// ----------------------------------------------------------------------------

// Tracks the hashing state of the key in flight and the hashes still owed.
class mm3_scoreboard;
    bit [31:0]   hash_acc;
    bit [23:0]   tail_bytes;
    bit [1:0]    tail_count;
    bit [31:0]   byte_count;
    bit [31:0]   expected_hashes[$];
    int unsigned errors;

    function new();
        clear();
        errors = 0;
    endfunction

    function void clear();
        hash_acc   = '0;
        tail_bytes = '0;
        tail_count = '0;
        byte_count = '0;
    endfunction

    // Rotation amounts used here are never zero.
    function bit [31:0] rol(bit [31:0] v, int unsigned n);
        return (v << n) | (v >> (32 - n));
    endfunction

    function bit [31:0] scramble_word(bit [31:0] k);
        k = k * mm3_pkg::C1_CONST;
        k = rol(k, 15);
        k = k * mm3_pkg::C2_CONST;
        return k;
    endfunction

    function void flag(string msg);
        errors++;
        if (errors <= 10) begin
            $display("%s", msg);
        end
    endfunction

    // Called for every item the block accepts.
    function void note_item(bit [31:0] seed, bit [7:0] kbyte, bit present, bit first,
                            bit last);
        bit [31:0] h;
        if (first) begin
            clear();
            hash_acc = seed;
        end
        if (present) begin
            byte_count++;
            // A fourth byte completes a little-endian word that is mixed in.
            if (tail_count == 2'd3) begin
                hash_acc ^= scramble_word({kbyte, tail_bytes});
                hash_acc = rol(hash_acc, 13) * 32'd5 + mm3_pkg::N_CONST;
                tail_bytes = '0;
                tail_count = '0;
            end else begin
                tail_bytes[8*tail_count +: 8] = kbyte;
                tail_count++;
            end
        end
        if (last) begin
            // Tail, length and the final avalanche.
            h = hash_acc;
            if (tail_count != 2'd0) begin
                h ^= scramble_word({8'h00, tail_bytes});
            end
            h ^= byte_count;
            h ^= h >> 16;
            h = h * mm3_pkg::F1_CONST;
            h ^= h >> 13;
            h = h * mm3_pkg::F2_CONST;
            h ^= h >> 16;
            expected_hashes.insert(expected_hashes.size(), h);
            clear();
        end
    endfunction

    // Called for every hash the block delivers.
    function void check_hash(bit [31:0] got);
        bit [31:0] want;
        if (expected_hashes.size() == 0) begin
            flag($sformatf("unexpected hash %08h with nothing outstanding", got));
        end else begin
            want = expected_hashes.pop_front();
            if (want != got) begin
                flag($sformatf("hash mismatch: expected %08h, got %08h", want, got));
            end
        end
    endfunction

    function int unsigned outstanding();
        return expected_hashes.size();
    endfunction

    function void close_out();
        foreach (expected_hashes[i]) begin
            flag($sformatf("expected hash %08h never arrived", expected_hashes[i]));
        end
    endfunction
endclass

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned KEY_ITEMS    = 1200;
    localparam int unsigned STALL_LIMIT  = 1000;
    localparam int unsigned DRAIN_CYCLES = 20;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;   // [31:0] key_seed, [39:32] key_byte
    logic [1:0]  s_tuser  = '0;   // [0] byte_present, [1] first_of_key
    logic        s_tlast  = 1'b0; // last_of_key
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;         // [31:0] hash_value

    mm3_scoreboard sb = new();

    bit          tx_idle_on    = 1'b1;
    bit          rx_idle_on    = 1'b1;
    int unsigned items_sent    = 0;
    int unsigned rx_stall_left = 0;
    int unsigned quiet_cycles  = 0;

    murmur3_32_key_hash u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5ns aclk = ~aclk;

    // Note accepted items and check delivered hashes at the rising edge.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                sb.note_item(s_tdata[31:0], s_tdata[39:32], s_tuser[0], s_tuser[1], s_tlast);
            end
            if (m_tvalid && m_tready) begin
                sb.check_hash(m_tdata);
            end
        end
    end

    // Watchdog on cycles in which neither side moves an item.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == STALL_LIMIT) begin
            $display("tb: errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Result side backpressure in random bursts.
    always @(negedge aclk) begin
        if (rx_stall_left != 0) begin
            rx_stall_left <= rx_stall_left - 1;
        end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
            rx_stall_left <= $urandom_range(0, 16);
            m_tready      <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Offer one item, possibly after an idle burst, and wait until it is taken.
    task automatic push_item(input bit [31:0] seed, input bit [7:0] kbyte,
                             input bit present, input bit first, input bit last);
        if (tx_idle_on && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {kbyte, seed};
        s_tuser  <= {first, present};
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        if (present || first || last) begin
            items_sent++;
        end
    endtask

    // Stop offering items until every owed hash has come out.
    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (sb.outstanding() != 0);
    endtask

    // Stream one key of random bytes. A key may lack its first mark, be
    // left open, or be closed by a separate no-byte item; stray no-byte
    // items may be mixed in.
    task automatic send_key(input bit [31:0] seed, input int unsigned nbytes,
                            input bit mark_first, input bit close_key,
                            input bit bare_last, input bit noisy);
        bit          first_flag;
        int unsigned i;
        first_flag = mark_first;
        for (i = 0; i < nbytes; i++) begin
            if (noisy && $urandom_range(0, 9) == 0) begin
                push_item($urandom, 8'($urandom), 1'b0, 1'b0, 1'b0);
            end
            push_item(first_flag ? seed : $urandom, 8'($urandom), 1'b1, first_flag,
                      close_key && !bare_last && i == nbytes - 1);
            first_flag = 1'b0;
        end
        if (close_key && (bare_last || nbytes == 0)) begin
            push_item(first_flag ? seed : $urandom, 8'($urandom), 1'b0, first_flag, 1'b1);
        end
    endtask

    initial begin
        int unsigned pick;
        int unsigned len;
        int unsigned i;

        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: empty keys at both seed extremes, one byte, a short
        // all-zero tail, a full all-ones word, a stray no-byte item, a key
        // without a first mark, a restart inside a key, and a key closed
        // by a no-byte last item.
        push_item(32'h0000_0000, 8'h00, 1'b0, 1'b1, 1'b1);
        push_item(32'hffff_ffff, 8'h00, 1'b0, 1'b1, 1'b1);
        push_item(32'hffff_ffff, 8'hff, 1'b1, 1'b1, 1'b1);
        push_item(32'h0000_0000, 8'h00, 1'b1, 1'b1, 1'b0);
        push_item(32'h0000_0000, 8'h00, 1'b1, 1'b0, 1'b0);
        push_item(32'h0000_0000, 8'h00, 1'b1, 1'b0, 1'b1);
        for (i = 0; i < 4; i++) begin
            push_item(32'h1234_5678, 8'hff, 1'b1, i == 0, i == 3);
        end
        push_item($urandom, 8'($urandom), 1'b0, 1'b0, 1'b0);
        send_key($urandom, 5, 1'b0, 1'b1, 1'b0, 1'b0);
        send_key($urandom, 2, 1'b1, 1'b0, 1'b0, 1'b0);
        send_key($urandom, 2, 1'b1, 1'b1, 1'b0, 1'b0);
        send_key($urandom, 6, 1'b1, 1'b1, 1'b1, 1'b0);
        hold_until_drained();

        // Random keys, mostly well formed and short.
        items_sent = 0;
        while (items_sent < KEY_ITEMS) begin
            // A quiet stretch in the middle and none at the end.
            tx_idle_on = items_sent < 1000 && !(items_sent >= 450 && items_sent < 650);
            rx_idle_on = tx_idle_on;
            pick = $urandom_range(0, 99);
            len  = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            if (pick < 65) begin
                send_key($urandom, len, 1'b1, 1'b1, 1'b0, 1'b1);
            end else if (pick < 73) begin
                send_key($urandom, 0, 1'($urandom_range(0, 1)), 1'b1, 1'b0, 1'b0);
            end else if (pick < 81) begin
                send_key($urandom, len, 1'b0, 1'b1, 1'b0, 1'b1);
            end else if (pick < 89) begin
                send_key($urandom, len, 1'b1, 1'b1, 1'b1, 1'b1);
            end else if (pick < 95) begin
                send_key($urandom, len, 1'b1, 1'b0, 1'b0, 1'b1);
            end else begin
                // A lone restart with no byte.
                push_item($urandom, 8'($urandom), 1'b0, 1'b1, 1'b0);
            end
            if ($urandom_range(0, 59) == 0) begin
                hold_until_drained();
            end
        end

        // Let the last hashes come out, then a short tail of cycles.
        hold_until_drained();
        repeat (DRAIN_CYCLES) @(negedge aclk);
        sb.close_out();
        if (sb.errors == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule
